// ===== rtl/core/plcmt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-mode timer: mode codes, register indexes, reset values
// and the flag and result structs shared by plcmt_step and the top level.
// No dependencies.
package plcmt_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int TIME_BITS_DEFAULT = 32;

    // Timer modes
    typedef enum logic [1:0] {
        MODE_ON_DELAY  = 2'd0,
        MODE_OFF_DELAY = 2'd1,
        MODE_CYCLIC    = 2'd2,
        MODE_PWM       = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME    = 2'd3;

    // Register reset values
    localparam mode_t             MODE_RESET     = MODE_CYCLIC;
    localparam logic [DATA_W-1:0] DURATION_RESET = 32'd1000;

    // Single-bit timer state
    typedef struct packed {
        logic running;
        logic prev_enable;
        logic pwm_phase;
        logic out_level;
    } flags_t;

    // One result beat
    typedef struct packed {
        logic              timer_out;
        logic              on_event;
        logic              off_event;
        logic [DATA_W-1:0] elapsed_ms;
    } result_t;

endpackage

// ===== rtl/core/plcmt_step.sv =====
`timescale 1ns / 1ps
// Combinational update step of the timer: next state and result for one beat.
// Depends on plcmt_pkg.
module plcmt_step
    import plcmt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  mode_t                 mode,
    input  logic [DATA_W-1:0]     duration,
    input  logic [DATA_W-1:0]     on_time,
    input  logic [DATA_W-1:0]     off_time,
    input  logic [TIME_BITS-1:0]  start_stamp,
    input  flags_t                flags,
    input  logic                  enable,
    input  logic                  restart_request,
    input  logic [DATA_W-1:0]     now_ms,
    output logic [TIME_BITS-1:0]  start_next,
    output flags_t                flags_next,
    output logic                  duration_load,
    output logic [DATA_W-1:0]     duration_value,
    output result_t               result
);

    // Compare width: wide enough for both time stamps and register values
    localparam int CW = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;
    localparam logic [CW-1:0] TMASK = {CW{1'b1}} >> (CW - TIME_BITS);

    logic [CW-1:0] now_w;
    logic [CW-1:0] since_old;

    // Wrap the stamp and take elapsed time against the stored start
    assign now_w     = CW'(now_ms) & TMASK;
    assign since_old = (now_w - CW'(start_stamp)) & TMASK;

    always_comb
    begin
        logic          delay_on;
        logic          delay_off;
        logic          edge_seen;
        logic          restarted;
        logic          run;
        logic          lvl;
        logic          phase;
        logic          ev_on;
        logic          ev_off;
        logic [CW-1:0] since;
        logic [DATA_W-1:0] cur_len;

        delay_on       = (mode == MODE_ON_DELAY);
        delay_off      = (mode == MODE_OFF_DELAY);
        restarted      = 1'b0;
        run            = flags.running;
        lvl            = flags.out_level;
        phase          = flags.pwm_phase;
        ev_on          = 1'b0;
        ev_off         = 1'b0;
        duration_load  = 1'b0;
        duration_value = duration;

        // Edge detect for the delay modes
        edge_seen = (delay_on && !flags.prev_enable && enable) ||
                    (delay_off && flags.prev_enable && !enable);

        // Restart wins over the stop from the enable level
        if (edge_seen || restart_request)
        begin
            restarted = 1'b1;
            run       = 1'b1;
        end
        else if ((delay_on && !enable) || (delay_off && enable))
        begin
            run = 1'b0;
            lvl = 1'b0;
        end

        // A fresh restart means zero elapsed
        since = restarted ? '0 : since_old;

        // Cyclic: toggle each time the period runs out
        if (mode == MODE_CYCLIC && enable)
        begin
            if (!run || since >= CW'(duration))
            begin
                ev_on     = 1'b1;
                restarted = 1'b1;
                run       = 1'b1;
                lvl       = !lvl;
            end
        end

        // PWM: swap phase at the end of the current phase and reload its length
        cur_len = phase ? on_time : off_time;
        if (mode == MODE_PWM && enable)
        begin
            if (!run || since >= CW'(cur_len))
            begin
                phase          = !phase;
                ev_on          = phase;
                ev_off         = !phase;
                restarted      = 1'b1;
                run            = 1'b1;
                duration_load  = 1'b1;
                duration_value = phase ? on_time : off_time;
                lvl            = !lvl;
            end
        end

        // Delay modes: hold the output high while expired
        if ((delay_on || delay_off) && run && since >= CW'(duration))
        begin
            ev_on = 1'b1;
            lvl   = 1'b1;
        end

        since = restarted ? '0 : since_old;

        start_next             = restarted ? now_w[TIME_BITS-1:0] : start_stamp;
        flags_next.running     = run;
        flags_next.prev_enable = enable;
        flags_next.pwm_phase   = phase;
        flags_next.out_level   = lvl;

        result.timer_out  = lvl;
        result.on_event   = ev_on;
        result.off_event  = ev_off;
        result.elapsed_ms = run ? since[DATA_W-1:0] : '0;
    end

endmodule

// ===== rtl/core/plc_style_multimode_timer_top.sv =====
`timescale 1ns / 1ps
// Multi-mode timer (on-delay, off-delay, cyclic, pwm), top level.
// An accepted input beat passes through the input stage, then the output register.
// Throughput: one beat per cycle while out_stall does not hold the output.
// Reset: asynchronous, active low; mode cyclic, duration 1000, other state zero.
// Depends on plcmt_pkg and plcmt_step.
module plc_style_multimode_timer_top
    import plcmt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 enable,
    input  logic                 restart_request,
    input  logic [DATA_W-1:0]    now_ms,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 timer_out,
    output logic                 on_event,
    output logic                 off_event,
    output logic [DATA_W-1:0]    elapsed_ms
);

    // Configuration registers
    mode_t                mode_reg;
    logic [DATA_W-1:0]    duration_reg;
    logic [DATA_W-1:0]    on_time_reg;
    logic [DATA_W-1:0]    off_time_reg;

    // Timer state
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] start_next;
    flags_t               flags_reg;
    flags_t               flags_next;
    logic                 duration_load;
    logic [DATA_W-1:0]    duration_value;

    // Input stage
    logic                 s1_valid_reg;
    logic                 s1_enable_reg;
    logic                 s1_restart_reg;
    logic [DATA_W-1:0]    s1_now_reg;

    // Output stage
    logic                 out_valid_reg;
    result_t              out_res_reg;
    result_t              step_res;

    logic                 out_load_ok;
    logic                 s1_fire;
    logic                 in_fire;

    assign out_load_ok = !out_valid_reg || !out_stall;
    assign s1_fire     = s1_valid_reg && out_load_ok;
    assign in_stall    = s1_valid_reg && !out_load_ok;
    assign in_fire     = in_valid && !in_stall;

    plcmt_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .mode            (mode_reg),
        .duration        (duration_reg),
        .on_time         (on_time_reg),
        .off_time        (off_time_reg),
        .start_stamp     (start_reg),
        .flags           (flags_reg),
        .enable          (s1_enable_reg),
        .restart_request (s1_restart_reg),
        .now_ms          (s1_now_reg),
        .start_next      (start_next),
        .flags_next      (flags_next),
        .duration_load   (duration_load),
        .duration_value  (duration_value),
        .result          (step_res)
    );

    // Configuration writes; pwm phase starts reload the duration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            duration_reg <= DURATION_RESET;
            on_time_reg  <= '0;
            off_time_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMER_MODE: mode_reg     <= mode_t'(cfg_wdata[1:0]);
                CFG_DURATION:   duration_reg <= cfg_wdata;
                CFG_ON_TIME:    on_time_reg  <= cfg_wdata;
                CFG_OFF_TIME:   off_time_reg <= cfg_wdata;
                default:        mode_reg     <= mode_reg;
            endcase
        end
        else if (s1_fire && duration_load)
        begin
            duration_reg <= duration_value;
        end
    end

    // Advance timer state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            flags_reg <= '0;
        end
        else if (s1_fire)
        begin
            start_reg <= start_next;
            flags_reg <= flags_next;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_enable_reg  <= enable;
            s1_restart_reg <= restart_request;
            s1_now_reg     <= now_ms;
        end
        if (s1_fire)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign timer_out  = out_res_reg.timer_out;
    assign on_event   = out_res_reg.on_event;
    assign off_event  = out_res_reg.off_event;
    assign elapsed_ms = out_res_reg.elapsed_ms;

    // On and off events never fire in the same update
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> !(step_res.on_event && step_res.off_event))
        else $error("on and off events fired together");

    // A stopped timer reports zero elapsed time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !flags_next.running) |-> (step_res.elapsed_ms == '0))
        else $error("elapsed time nonzero while timer stopped");

    // Input only stalls when both stages are occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // A processed beat always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed beat lost");

endmodule
